>>> hw/rtl/swmo_pkg.sv
// ----------------------------------------------------------------------------
// swmo_pkg: shared types and constants for the stack with middle access
// Holds the stack depth, derived widths, request and status codes and the
// control word broadcast from the top level to every storage cell.
// ----------------------------------------------------------------------------
package swmo_pkg;

	// Stack geometry.
	localparam int DEPTH = 64;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Word widths.
	localparam int DATA_W  = 32;
	localparam int DEPTH_W = 7;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;

	// Request codes.
	typedef enum logic [OP_W-1:0] {
		OP_PUSH    = 2'd0,
		OP_POP     = 2'd1,
		OP_READ    = 2'd2,
		OP_DEL_MID = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} stat_t;

	// Control word seen by every cell in the same cycle.
	typedef struct packed {
		logic             push_en;
		logic             del_en;
		logic             sel_en;
		logic [CNT_W-1:0] count;
		logic [IDX_W-1:0] mid;
	} cell_ctl_t;

endpackage

>>> hw/rtl/swmo_cell.sv
// ----------------------------------------------------------------------------
// swmo_cell: one storage place of the stack
// Holds one word. Takes the pushed word when it is the next free place, takes
// its upper neighbor's word when a middle delete closes the gap, and offers
// its word to the middle selection when it sits at the middle index.
// ----------------------------------------------------------------------------
module swmo_cell (
	input  logic                       clk,
	input  logic [swmo_pkg::IDX_W-1:0]  idx,
	input  swmo_pkg::cell_ctl_t         ctl,
	input  logic [swmo_pkg::DATA_W-1:0] push_value,
	input  logic [swmo_pkg::DATA_W-1:0] above,
	output logic [swmo_pkg::DATA_W-1:0] value,
	output logic [swmo_pkg::DATA_W-1:0] mid_word
);
	import swmo_pkg::*;

	logic [DATA_W-1:0] value_q;
	logic              take_push;
	logic              take_above;

	// Decide what this place loads in the current cycle.
	always_comb begin
		take_push  = ctl.push_en && (CNT_W'(idx) == ctl.count);
		take_above = ctl.del_en && (idx >= ctl.mid) &&
			((CNT_W'(idx) + CNT_W'(1)) < ctl.count);
	end

	// Stored word; contents are meaningless until written.
	always_ff @(posedge clk) begin
		if (take_push) begin
			value_q <= push_value;
		end else if (take_above) begin
			value_q <= above;
		end
	end

	assign value    = value_q;
	assign mid_word = (ctl.sel_en && (idx == ctl.mid)) ? value_q : '0;

endmodule

>>> hw/rtl/stack_with_middle_ops.sv
// ----------------------------------------------------------------------------
// stack_with_middle_ops: bounded stack of signed words with middle access
// An accepted request first updates the cells and the element count; the
// middle selection then goes into the output register once that is free.
// A new request is taken only after the last one reached that register.
// Reset clears the element count and all handshake state; stored words stay
// undefined until pushed.
// ----------------------------------------------------------------------------
module stack_with_middle_ops (
	input  logic                       clk,
	input  logic                       arst_n,
	// Request side.
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,  // [31:0] push_value
	input  logic [1:0]                 s_tuser,  // [1:0] op
	// Result side.
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [39:0]                m_tdata,  // [31:0] middle_value, [38:32] depth_now
	output logic [1:0]                 m_tuser   // [1:0] status
);
	import swmo_pkg::*;

	logic              busy_q;
	logic [CNT_W-1:0]  count_q;
	stat_t             stat_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_mid_q;
	logic [DEPTH_W-1:0] out_depth_q;
	stat_t             out_stat_q;

	logic              accept;
	logic              finish;
	op_t               op;
	logic              is_empty;
	logic              is_full;
	stat_t             stat_next;
	logic [CNT_W-1:0]  count_next;
	cell_ctl_t         ctl;
	logic [DATA_W-1:0] mid_or;

	logic [DATA_W-1:0] cell_value [DEPTH];
	logic [DATA_W-1:0] cell_mid   [DEPTH];

	assign op       = op_t'(s_tuser);
	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign finish   = busy_q && (!out_valid_q || m_tready);
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q >= CNT_W'(DEPTH));

	// Request decode: status and new count.
	always_comb begin
		stat_next  = ST_OK;
		count_next = count_q;
		unique case (op)
			OP_PUSH: begin
				if (is_full) begin
					stat_next = ST_FULL;
				end else begin
					count_next = count_q + CNT_W'(1);
				end
			end
			OP_POP, OP_DEL_MID: begin
				if (is_empty) begin
					stat_next = ST_EMPTY;
				end else begin
					count_next = count_q - CNT_W'(1);
				end
			end
			OP_READ: begin
				if (is_empty) begin
					stat_next = ST_EMPTY;
				end
			end
			default: begin
				stat_next = ST_OK;
			end
		endcase
	end

	// Control word broadcast to the cells.
	always_comb begin
		ctl.push_en = accept && (op == OP_PUSH) && !is_full;
		ctl.del_en  = accept && (op == OP_DEL_MID) && !is_empty;
		ctl.sel_en  = !is_empty;
		ctl.count   = count_q;
		ctl.mid     = IDX_W'((count_q - CNT_W'(1)) >> 1);
	end

	// Row of storage cells; each one sees its upper neighbor.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_W-1:0] above_w;
		if (g == DEPTH - 1) begin : g_top
			assign above_w = '0;
		end else begin : g_mid
			assign above_w = cell_value[g+1];
		end
		swmo_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(g)),
			.ctl        (ctl),
			.push_value (s_tdata),
			.above      (above_w),
			.value      (cell_value[g]),
			.mid_word   (cell_mid[g])
		);
	end

	// Only the middle cell offers a nonzero word, so an OR picks it out.
	always_comb begin
		mid_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			mid_or = mid_or | cell_mid[i];
		end
	end

	// Request tracking: count, pending status and the busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (accept) begin
				busy_q  <= 1'b1;
				count_q <= count_next;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stat_q <= stat_next;
		end
	end

	// Output register: holds a result word until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_mid_q   <= mid_or;
			out_depth_q <= DEPTH_W'(count_q);
			out_stat_q  <= stat_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_depth_q, out_mid_q};
	assign m_tuser  = out_stat_q;

endmodule
